>>> src/x86dec_pkg.sv
`timescale 1ns / 1ps

package x86dec_pkg;

  // Opcode match patterns and masks
  localparam logic [7:0] MOV_IMM_REG_PAT  = 8'b1011_0000;
  localparam logic [7:0] MOV_IMM_REG_MASK = 8'b1111_0000;
  localparam logic [7:0] MOV_RM_PAT       = 8'b1000_1000;
  localparam logic [7:0] GRP_IMM_PAT      = 8'b1000_0000;
  localparam logic [7:0] TWO_LSB_MASK     = 8'b1111_1100;
  localparam logic [7:0] ALU_RM_MASK      = 8'b1100_0100;
  localparam logic [7:0] ALU_RM_PAT       = 8'b0000_0000;
  localparam logic [7:0] ALU_ACC_MASK     = 8'b1100_0110;
  localparam logic [7:0] ALU_ACC_PAT      = 8'b0000_0100;

  // ALU operation codes inside the opcode or the ModRM reg field
  localparam logic [2:0] OOO_ADD = 3'b000;
  localparam logic [2:0] OOO_SUB = 3'b101;
  localparam logic [2:0] OOO_CMP = 3'b111;

  // Reported operation
  localparam logic [1:0] OP_MOV = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_SUB = 2'd2;
  localparam logic [1:0] OP_CMP = 2'd3;

  // Reported instruction form
  localparam logic [1:0] FORM_REG_RM  = 2'd0;
  localparam logic [1:0] FORM_IMM_RM  = 2'd1;
  localparam logic [1:0] FORM_IMM_ACC = 2'd2;
  localparam logic [1:0] FORM_IMM_REG = 2'd3;

  // ModRM mod field values
  localparam logic [1:0] MOD_MEM      = 2'd0;
  localparam logic [1:0] MOD_DISP8    = 2'd1;
  localparam logic [1:0] MOD_DISP16   = 2'd2;
  localparam logic [2:0] RM_DIRECT    = 3'b110;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
  } dec_win_t;

  typedef struct packed {
    logic               valid_res;
    logic [1:0]         operation;
    logic [1:0]         form;
    logic               wide;
    logic               to_reg;
    logic [1:0]         mod_bits;
    logic [2:0]         reg_bits;
    logic [2:0]         rm_bits;
    logic signed [15:0] displacement;
    logic [15:0]        immediate;
    logic [2:0]         length;
  } dec_res_t;

endpackage

>>> src/x86dec_ifs.sv
`timescale 1ns / 1ps

interface x86dec_in_if import x86dec_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [7:0] byte5;

  modport source (output valid, byte0, byte1, byte2, byte3, byte4, byte5, input ready);
  modport sink   (input valid, byte0, byte1, byte2, byte3, byte4, byte5, output ready);
endinterface

interface x86dec_out_if import x86dec_pkg::*; ();
  logic     valid;
  logic     ready;
  dec_res_t res;

  modport source (output valid, res, input ready);
  modport sink   (input valid, res, output ready);
endinterface

>>> src/x86dec_decode.sv
`timescale 1ns / 1ps

module x86dec_decode import x86dec_pkg::*; (
  input  dec_win_t win,
  output dec_res_t res
);

  // map ooo to the reported operation; MOV code marks an unsupported ooo
  function automatic logic [1:0] alu_op(input logic [2:0] ooo);
    logic [1:0] op;
    begin
      case (ooo)
        OOO_ADD: op = OP_ADD;
        OOO_SUB: op = OP_SUB;
        OOO_CMP: op = OP_CMP;
        default: op = OP_MOV;
      endcase
      return op;
    end
  endfunction

  logic [7:0]  b0;
  logic [1:0]  mrm_mod;
  logic [2:0]  mrm_reg;
  logic [2:0]  mrm_rm;
  logic [1:0]  op_b0;
  logic [1:0]  op_b1;
  logic        is_mov_ir;
  logic        is_reg_rm;
  logic        is_grp;
  logic        is_acc;
  logic [15:0] disp;
  logic [1:0]  disp_len;
  logic [7:0]  imm_lo;
  logic [7:0]  imm_hi;

  assign b0      = win.byte0;
  assign mrm_mod = win.byte1[7:6];
  assign mrm_reg = win.byte1[5:3];
  assign mrm_rm  = win.byte1[2:0];
  assign op_b0   = alu_op(b0[5:3]);
  assign op_b1   = alu_op(mrm_reg);

  assign is_mov_ir = (b0 & MOV_IMM_REG_MASK) == MOV_IMM_REG_PAT;
  assign is_reg_rm = ((b0 & TWO_LSB_MASK) == MOV_RM_PAT) ||
                     (((b0 & ALU_RM_MASK) == ALU_RM_PAT) && (op_b0 != OP_MOV));
  assign is_grp    = ((b0 & TWO_LSB_MASK) == GRP_IMM_PAT) && (op_b1 != OP_MOV);
  assign is_acc    = ((b0 & ALU_ACC_MASK) == ALU_ACC_PAT) && (op_b0 != OP_MOV);

  // ModRM displacement: disp8 sign-extends, mod 10 and direct address take a word
  always_comb begin
    disp     = 16'h0000;
    disp_len = 2'd0;
    if (mrm_mod == MOD_DISP8) begin
      disp     = {{8{win.byte2[7]}}, win.byte2};
      disp_len = 2'd1;
    end else if ((mrm_mod == MOD_DISP16) || ((mrm_mod == MOD_MEM) && (mrm_rm == RM_DIRECT))) begin
      disp     = {win.byte3, win.byte2};
      disp_len = 2'd2;
    end
  end

  // immediate bytes of the group form follow the displacement
  always_comb begin
    case (disp_len)
      2'd0:    begin imm_lo = win.byte2; imm_hi = win.byte3; end
      2'd1:    begin imm_lo = win.byte3; imm_hi = win.byte4; end
      2'd2:    begin imm_lo = win.byte4; imm_hi = win.byte5; end
      default: begin imm_lo = win.byte4; imm_hi = win.byte5; end
    endcase
  end

  always_comb begin
    res = '0;
    if (is_mov_ir) begin
      res.valid_res = 1'b1;
      res.operation = OP_MOV;
      res.form      = FORM_IMM_REG;
      res.to_reg    = 1'b1;
      res.wide      = b0[3];
      res.reg_bits  = b0[2:0];
      res.immediate = b0[3] ? {win.byte2, win.byte1} : {8'h00, win.byte1};
      res.length    = b0[3] ? 3'd3 : 3'd2;
    end else if (is_reg_rm) begin
      res.valid_res    = 1'b1;
      res.operation    = (b0[7:6] == 2'b00) ? op_b0 : OP_MOV;
      res.form         = FORM_REG_RM;
      res.wide         = b0[0];
      res.to_reg       = b0[1];
      res.mod_bits     = mrm_mod;
      res.reg_bits     = mrm_reg;
      res.rm_bits      = mrm_rm;
      res.displacement = disp;
      res.length       = 3'd2 + {1'b0, disp_len};
    end else if (is_grp) begin
      res.valid_res    = 1'b1;
      res.operation    = op_b1;
      res.form         = FORM_IMM_RM;
      res.wide         = b0[0];
      res.mod_bits     = mrm_mod;
      res.reg_bits     = mrm_reg;
      res.rm_bits      = mrm_rm;
      res.displacement = disp;
      if (b0[0] && !b0[1]) begin
        res.immediate = {imm_hi, imm_lo};
        res.length    = 3'd4 + {1'b0, disp_len};
      end else if (b0[0]) begin
        res.immediate = {{8{imm_lo[7]}}, imm_lo};
        res.length    = 3'd3 + {1'b0, disp_len};
      end else begin
        res.immediate = {8'h00, imm_lo};
        res.length    = 3'd3 + {1'b0, disp_len};
      end
    end else if (is_acc) begin
      res.valid_res = 1'b1;
      res.operation = op_b0;
      res.form      = FORM_IMM_ACC;
      res.wide      = b0[0];
      res.to_reg    = 1'b1;
      res.immediate = b0[0] ? {win.byte2, win.byte1} : {8'h00, win.byte1};
      res.length    = b0[0] ? 3'd3 : 3'd2;
    end
  end

endmodule

>>> src/x86_16_mov_alu_decoder_top.sv
`timescale 1ns / 1ps

// Decoder for a subset of 16-bit x86 instructions: MOV immediate to register,
// MOV register with register/memory, and ADD/SUB/CMP in the register/memory,
// immediate to register/memory and immediate to accumulator forms. Each input
// request carries a six-byte window that starts at the opcode; each one yields
// exactly one result request with the operation, form, w/d bits, ModRM fields,
// displacement (disp8 sign-extended, direct address for mod 00 r/m 110),
// immediate (sign-extended byte when s=1 and w=1 in the immediate group) and
// length in bytes. An opcode outside these forms, or an ALU code other than ADD,
// SUB or CMP, gives valid_res low with every other field zero. The block takes
// one request per cycle while out_if.ready is high: the window is captured in an
// input register, decoded by a single combinational pass, and the record is
// held in a result register. While a finished result waits on out_if.ready, a
// new request is still taken if the input register is empty; input ready drops
// only when both stages hold data and the output is stalled.
module x86_16_mov_alu_decoder_top import x86dec_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  x86dec_in_if.sink   in_if,
  x86dec_out_if.source out_if
);

  dec_win_t win_r;
  logic     s1_v_r;
  dec_res_t dec_res;
  dec_res_t res_r;
  logic     s2_v_r;
  logic     s2_adv;
  logic     s1_rdy;

  // advance the result stage when it is empty or being drained
  assign s2_adv = !s2_v_r || out_if.ready;
  // take a new request when the input stage is empty or moving on
  assign s1_rdy = !s1_v_r || s2_adv;

  assign in_if.ready  = s1_rdy;
  assign out_if.valid = s2_v_r;
  assign out_if.res   = res_r;

  x86dec_decode u_decode (
    .win (win_r),
    .res (dec_res)
  );

  // hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= in_if.valid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  // capture payload only when a stage actually loads
  always_ff @(posedge clk) begin
    if (s1_rdy && in_if.valid) begin
      win_r <= '{byte0: in_if.byte0, byte1: in_if.byte1, byte2: in_if.byte2,
                 byte3: in_if.byte3, byte4: in_if.byte4, byte5: in_if.byte5};
    end
    if (s2_adv && s1_v_r) begin
      res_r <= dec_res;
    end
  end

  // a decoded window moves into the result stage whenever that stage frees up
  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s2_adv |=> s2_v_r)
    else $error("decoded request dropped between stages");

  // back-pressure at the input only when both stages are full and output stalls
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (s1_v_r && s2_v_r && !out_if.ready))
    else $error("input stalled while pipeline has room");

  // a valid record spans two to six bytes, an invalid one reports no length
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.res.valid_res ?
      (out_if.res.length >= 3'd2 && out_if.res.length <= 3'd6) :
      (out_if.res.length == 3'd0)))
    else $error("result length inconsistent with valid_res");

endmodule
